/* rtl/bkla_pkg.sv */
// shared types, constants and register codes for the binned k-lowest average block
package bkla_pkg;

    localparam int MaxBins   = 64;
    localparam int MaxKeep   = 8;
    localparam int BinW      = $clog2(MaxBins);
    localparam int KeepW     = $clog2(MaxKeep);
    localparam int CntW      = KeepW + 1;
    localparam int SlotW     = BinW + KeepW;
    localparam int DataW     = 32;
    localparam int QueueDepth = 4;
    localparam int QueueAw   = $clog2(QueueDepth);

    localparam logic [1:0] RegXMin      = 2'd0;
    localparam logic [1:0] RegStepRecip = 2'd1;
    localparam logic [1:0] RegNumBins   = 2'd2;
    localparam logic [1:0] RegKeepCount = 2'd3;

    typedef struct packed {
        logic              finish;
        logic [BinW-1:0]   bin;
        logic signed [DataW-1:0] y;
    } cmd_t;

    typedef struct packed {
        logic [6:0] nb;
        logic [3:0] keep;
    } cfg_t;

endpackage

/* rtl/bkla_front.sv */
// front part: computes the bin of each sample, drops those outside the bins and passes finish requests on
module bkla_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic signed [31:0]        x_value,
    input  logic signed [31:0]        y_value,
    input  logic signed [31:0]        x_min,
    input  logic [31:0]               step_recip,
    input  logic [6:0]                nb_eff,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output bkla_pkg::cmd_t            cmd
);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_OUT  = 4'b1000
    } fstate_t;

    fstate_t                state_reg, state_next;
    logic                   fin_reg;
    logic signed [32:0]     diff_reg;
    logic signed [31:0]     y_reg;
    logic [63:0]            plo_reg;
    logic [31:0]            phi_reg;
    logic [33:0]            idx_reg;
    logic                   keep_reg;
    logic signed [32:0]     diff_c;
    logic [33:0]            idx_c;

    assign req_ready = (state_reg == ST_IDLE);
    assign cmd_valid = (state_reg == ST_OUT);
    assign diff_c    = 33'(x_value) - 33'(x_min);
    assign idx_c     = 34'(phi_reg) + 34'(plo_reg[63:32]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req_valid) state_next = req_type ? ST_OUT : ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = (!diff_reg[32] && idx_c < 34'(nb_eff)) ? ST_OUT : ST_IDLE;
            ST_OUT:  if (cmd_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            fin_reg  <= req_type;
            diff_reg <= diff_c;
            y_reg    <= y_value;
        end
        if (state_reg == ST_MUL)
        begin
            plo_reg <= 64'(diff_reg[31:0]) * 64'(step_recip);
            phi_reg <= diff_reg[32] ? 32'd0 : 32'd0;
        end
        if (state_reg == ST_SUM)
        begin
            idx_reg  <= idx_c;
            keep_reg <= 1'b1;
        end
    end

    assign cmd.finish = fin_reg;
    assign cmd.bin    = idx_reg[bkla_pkg::BinW-1:0] & {bkla_pkg::BinW{keep_reg | ~fin_reg}};
    assign cmd.y      = y_reg;

endmodule

/* rtl/bkla_queue.sv */
// short request queue between the front and back parts
module bkla_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bkla_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output bkla_pkg::cmd_t  out_cmd
);

    bkla_pkg::cmd_t                   mem_reg [bkla_pkg::QueueDepth];
    logic [bkla_pkg::QueueAw-1:0]     wr_reg, rd_reg;
    logic [bkla_pkg::QueueAw:0]       cnt_reg;
    logic                             push, pop;

    assign in_ready  = (cnt_reg != (bkla_pkg::QueueAw+1)'(bkla_pkg::QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= in_cmd;
    end

endmodule

/* rtl/bkla_back.sv */
// back part: sorted insert into the bin store and per-bin averages on finish
module bkla_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  bkla_pkg::cmd_t        cmd,
    input  bkla_pkg::cfg_t        cfg,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [5:0]            bin_index,
    output logic signed [31:0]    average,
    output logic [3:0]            kept_points,
    output logic                  short_of_points,
    output logic                  last
);

    localparam int BW = bkla_pkg::BinW;
    localparam int KW = bkla_pkg::KeepW;
    localparam int CW = bkla_pkg::CntW;

    typedef enum logic [11:0]
    {
        ST_IDLE  = 12'b000000000001,
        ST_LOAD  = 12'b000000000010,
        ST_SCAN  = 12'b000000000100,
        ST_SWAIT = 12'b000000001000,
        ST_DEC   = 12'b000000010000,
        ST_SHIFT = 12'b000000100000,
        ST_SWR   = 12'b000001000000,
        ST_PUT   = 12'b000010000000,
        ST_FSUM  = 12'b000100000000,
        ST_DIV   = 12'b001000000000,
        ST_EMIT  = 12'b010000000000,
        ST_CLR   = 12'b100000000000
    } bstate_t;

    bstate_t                  state_reg;
    logic signed [31:0]       mem [bkla_pkg::MaxBins*bkla_pkg::MaxKeep];
    logic [CW-1:0]            cnt_mem [bkla_pkg::MaxBins];
    logic [CW-1:0]            cnt_rd_reg;
    logic [BW-1:0]            cnt_raddr, cnt_waddr, clr_reg;
    logic [CW-1:0]            cnt_wdata;
    logic                     cnt_we;
    logic                     drop_c;
    logic                     fin_reg;
    logic signed [31:0]       rd_data_reg;
    logic [BW+KW-1:0]         rd_addr;
    logic                     rd_en;
    logic [BW-1:0]            bin_reg;
    logic signed [31:0]       y_reg;
    logic [CW-1:0]            n_reg, pos_reg, i_reg;
    logic                     dup_reg;
    logic signed [34:0]       sum_reg;
    logic [34:0]              mag_reg, quo_reg, rem_reg;
    logic                     neg_reg;
    logic [5:0]               dstep_reg;
    logic [KW:0]              keep_eff;
    logic [6:0]               nb_eff;
    logic signed [31:0]       shift_val_reg;
    logic [35:0]              rem_try;
    logic [34:0]              quo_fix;

    assign keep_eff  = (cfg.keep == 4'd0) ? (KW+1)'(1) :
                       (cfg.keep > 4'(bkla_pkg::MaxKeep)) ? (KW+1)'(bkla_pkg::MaxKeep) :
                       (KW+1)'(cfg.keep);
    assign nb_eff    = (cfg.nb > 7'(bkla_pkg::MaxBins)) ? 7'(bkla_pkg::MaxBins) : cfg.nb;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign rem_try   = {rem_reg, mag_reg[34]} - 36'(n_reg);
    assign quo_fix   = neg_reg ? (~quo_reg + 35'd1) : quo_reg;
    // full bin: y at or above the highest kept value leaves the bin as it is
    assign drop_c    = (pos_reg == n_reg) || (dup_reg && (pos_reg + 1'b1 == n_reg));

    always_comb
    begin
        rd_addr = {bin_reg, i_reg[KW-1:0]};
        rd_en   = (state_reg == ST_SCAN) || (state_reg == ST_SHIFT) || (state_reg == ST_FSUM);
    end

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = bin_reg;
        cnt_wdata = n_reg + 1'b1;
        cnt_raddr = bin_reg;
        case (state_reg)
            ST_IDLE: cnt_raddr = cmd.finish ? '0 : cmd.bin;
            ST_EMIT: cnt_raddr = bin_reg + 1'b1;
            ST_DEC:
                if (n_reg >= CW'(keep_eff) && !drop_c)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = n_reg - 1'b1;
                end
            ST_PUT:  cnt_we = 1'b1;
            ST_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
        if (state_reg == ST_SWR)
            mem[{bin_reg, i_reg[KW-1:0]}] <= shift_val_reg;
        else if (state_reg == ST_PUT)
            mem[{bin_reg, pos_reg[KW-1:0]}] <= y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            fin_reg <= 1'b0;
            bin_reg <= '0;
            i_reg   <= '0;
            n_reg   <= '0;
            pos_reg <= '0;
            dup_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (cmd_valid)
                    begin
                        y_reg   <= cmd.y;
                        i_reg   <= '0;
                        dup_reg <= 1'b0;
                        fin_reg <= cmd.finish;
                        if (cmd.finish)
                        begin
                            bin_reg <= '0;
                            state_reg <= (nb_eff == 7'd0) ? ST_CLR : ST_LOAD;
                        end
                        else
                        begin
                            bin_reg <= cmd.bin;
                            state_reg <= ST_LOAD;
                        end
                    end
                ST_LOAD:
                begin
                    n_reg <= cnt_rd_reg;
                    i_reg <= '0;
                    if (fin_reg)
                    begin
                        sum_reg   <= '0;
                        state_reg <= ST_FSUM;
                    end
                    else
                    begin
                        pos_reg   <= cnt_rd_reg;
                        state_reg <= (cnt_rd_reg == '0) ? ST_PUT : ST_SCAN;
                    end
                end
                // linear scan: pos = first index with v >= y
                ST_SCAN:  state_reg <= ST_SWAIT;
                ST_SWAIT:
                    if (rd_data_reg >= y_reg)
                    begin
                        pos_reg <= i_reg;
                        dup_reg <= (rd_data_reg == y_reg);
                        i_reg   <= n_reg - 1'b1;
                        state_reg <= ST_DEC;
                    end
                    else if (i_reg + 1'b1 == n_reg)
                    begin
                        pos_reg <= n_reg;
                        i_reg   <= n_reg - 1'b1;
                        state_reg <= ST_DEC;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                ST_DEC:
                    if (n_reg >= CW'(keep_eff))
                    begin
                        // full: y must be below highest; drop highest
                        if (drop_c)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            n_reg <= n_reg - 1'b1;
                            if (dup_reg)
                                state_reg <= ST_IDLE;
                            else
                            begin
                                i_reg <= n_reg - 1'b1;
                                state_reg <= (n_reg - 1'b1 > pos_reg) ? ST_SHIFT : ST_PUT;
                            end
                        end
                    end
                    else if (dup_reg)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        i_reg <= n_reg;
                        state_reg <= (n_reg > pos_reg) ? ST_SHIFT : ST_PUT;
                    end
                // shift entries pos..n-1 up one, from the top down
                ST_SHIFT: state_reg <= ST_SWR;
                ST_SWR:
                begin
                    i_reg <= i_reg - 1'b1;
                    if (i_reg > pos_reg + 1'b1)
                        state_reg <= ST_SHIFT;
                    else
                        state_reg <= ST_PUT;
                end
                ST_PUT:   state_reg <= ST_IDLE;
                ST_FSUM:
                begin
                    if (i_reg != '0)
                        sum_reg <= sum_reg + 35'(rd_data_reg);
                    if (i_reg == n_reg)
                    begin
                        state_reg <= ST_DIV;
                        dstep_reg <= '0;
                        quo_reg   <= '0;
                        rem_reg   <= '0;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_DIV:
                begin
                    if (dstep_reg == 6'd0)
                    begin
                        neg_reg <= sum_reg[34];
                        mag_reg <= sum_reg[34] ? (~sum_reg + 35'd1) : sum_reg;
                    end
                    else
                    begin
                        if (!rem_try[35])
                        begin
                            rem_reg <= rem_try[34:0];
                            quo_reg <= {quo_reg[33:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[33:0], mag_reg[34]};
                            quo_reg <= {quo_reg[33:0], 1'b0};
                        end
                        mag_reg <= {mag_reg[33:0], 1'b0};
                    end
                    if (dstep_reg == 6'd35 || n_reg == '0)
                        state_reg <= ST_EMIT;
                    dstep_reg <= dstep_reg + 1'b1;
                end
                ST_EMIT:
                    if (res_ready)
                    begin
                        if (7'(bin_reg) + 7'd1 == nb_eff)
                            state_reg <= ST_CLR;
                        else
                        begin
                            bin_reg <= bin_reg + 1'b1;
                            state_reg <= ST_LOAD;
                        end
                    end
                // one bin count cleared per cycle over all bins
                ST_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BW'(bkla_pkg::MaxBins - 1))
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // value moved up one slot during a shift
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SHIFT)
            shift_val_reg <= mem[{bin_reg, KW'(i_reg - 1'b1)}];
    end

    assign bin_index       = bin_reg;
    assign average         = (n_reg == '0) ? 32'sd0 : quo_fix[31:0];
    assign kept_points     = 4'(n_reg);
    assign short_of_points = ((KW+1)'(n_reg) < keep_eff);
    assign last            = (7'(bin_reg) + 7'd1 == nb_eff);

endmodule

/* rtl/binned_k_lowest_average.sv */
// top level of the binned k-lowest average block
// sample: the front computes the bin, then the back places it in the bin store by a serial scan and shift
// finish: per bin a sum walk and a 35-step divider, cut short for an empty bin, then a clear of the bin counts
// a four-entry request queue lets the front take requests while the back is busy
// reset restores register defaults and starts a pass that clears the bin counts
module binned_k_lowest_average
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic signed [31:0]  x_value,
    input  logic signed [31:0]  y_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          bin_index,
    output logic signed [31:0]  average,
    output logic [3:0]          kept_points,
    output logic                short_of_points,
    output logic                last
);

    logic signed [31:0]  x_min_reg;
    logic [31:0]         step_recip_reg;
    logic [6:0]          num_bins_reg;
    logic [3:0]          keep_count_reg;
    logic                fq_valid, fq_ready, qb_valid, qb_ready;
    bkla_pkg::cmd_t      fq_cmd, qb_cmd;
    bkla_pkg::cfg_t      cfg;
    logic [6:0]          nb_eff;

    assign pready = 1'b1;
    assign cfg.nb   = num_bins_reg;
    assign cfg.keep = keep_count_reg;
    assign nb_eff = (num_bins_reg > 7'(bkla_pkg::MaxBins)) ? 7'(bkla_pkg::MaxBins) : num_bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg      <= '0;
            step_recip_reg <= 32'd65536;
            num_bins_reg   <= 7'd64;
            keep_count_reg <= 4'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                bkla_pkg::RegXMin:      x_min_reg      <= pwdata;
                bkla_pkg::RegStepRecip: step_recip_reg <= pwdata;
                bkla_pkg::RegNumBins:   num_bins_reg   <= pwdata[6:0];
                bkla_pkg::RegKeepCount: keep_count_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bkla_pkg::RegXMin:      prdata = x_min_reg;
            bkla_pkg::RegStepRecip: prdata = step_recip_reg;
            bkla_pkg::RegNumBins:   prdata = {25'd0, num_bins_reg};
            bkla_pkg::RegKeepCount: prdata = {28'd0, keep_count_reg};
            default:                prdata = '0;
        endcase
    end

    bkla_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid),
        .req_ready  (in_ready),
        .req_type   (req_type),
        .x_value    (x_value),
        .y_value    (y_value),
        .x_min      (x_min_reg),
        .step_recip (step_recip_reg),
        .nb_eff     (nb_eff),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    bkla_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    bkla_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (qb_valid),
        .cmd_ready       (qb_ready),
        .cmd             (qb_cmd),
        .cfg             (cfg),
        .res_valid       (out_valid),
        .res_ready       (out_ready),
        .bin_index       (bin_index),
        .average         (average),
        .kept_points     (kept_points),
        .short_of_points (short_of_points),
        .last            (last)
    );

endmodule

/* rtl/bkla_checker.sv */
// port-level checks for the binned k-lowest average block
module bkla_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  bin_index,
    input logic [3:0]  kept_points,
    input logic        last,
    input logic        pready
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_index))
        else $error("result changed while stalled");

    a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kept_points <= 4'd8)
        else $error("kept count out of range");

    a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last ##1 out_valid |-> bin_index != 6'd0)
        else $error("bin order broken");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind binned_k_lowest_average bkla_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_index   (bin_index),
    .kept_points (kept_points),
    .last        (last),
    .pready      (pready)
);
